// ----- rtl/vtp_pkg.sv -----
// Shared types, constants and reset values for the vertex transform and divide block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package vtp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int REG_AW        = $clog2(NUM_REGS);
    localparam int IDX_W         = REG_AW + 1;
    // Width of a homogeneous column value, enough for every FRAC_BITS in range.
    localparam int CW            = 67;
    // Quotient bits kept; anything larger saturates.
    localparam int QW            = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [63:0] COEF_RST_LO_ONE = 64'h0000_0000_0001_0000;
    localparam logic [63:0] COEF_RST_HI_ONE = 64'h0001_0000_0000_0000;
    localparam logic [63:0] COEF_RST_ZERO   = 64'h0;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } vtp_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_was_zero;
        logic               saturated;
    } vtp_out_t;

    typedef struct packed {
        logic [CW-1:0] n;     // magnitude of the undivided coordinate
        logic [QW-1:0] lo;    // low dividend bits still to be shifted in
        logic [CW-1:0] rem;   // partial remainder
        logic [QW-1:0] q;     // quotient bits so far
        logic          big;   // quotient does not fit in QW bits
        logic          neg;   // coordinate was negative
    } vtp_coord_t;

    typedef struct packed {
        vtp_coord_t [2:0] c;
        logic [CW-1:0]    d;
        logic             w_neg;
        logic             wz;
    } vtp_job_t;

    function automatic logic [63:0] coef_reset(input int idx);
        logic [63:0] v;
        case (idx)
            0:       v = COEF_RST_LO_ONE;
            2:       v = COEF_RST_HI_ONE;
            5:       v = COEF_RST_LO_ONE;
            7:       v = COEF_RST_HI_ONE;
            default: v = COEF_RST_ZERO;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/vtp_front.sv -----
// Front pipeline: matrix products, column sums, magnitudes and divide setup.
// Depends on vtp_pkg.
`default_nettype none
module vtp_front #(
    parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire vtp_pkg::vtp_in_t  in_data,
    input  wire logic [63:0]       coef [vtp_pkg::NUM_REGS],
    output logic                   job_valid,
    input  wire logic              job_ready,
    output vtp_pkg::vtp_job_t      job
);

    localparam int NST = 5;
    localparam int CW  = vtp_pkg::CW;
    localparam int QW  = vtp_pkg::QW;
    localparam int BW  = CW + QW;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] adv;

    logic signed [31:0] mc [4][4];
    logic signed [31:0] xv [3];

    logic signed [63:0]   p_reg   [3][4];
    logic signed [65:0]   s_reg   [4];
    logic signed [CW-1:0] col_reg [4];
    logic [CW-1:0]        n_reg   [3];
    logic                 neg_reg [3];
    logic [CW-1:0]        d_reg;
    logic                 wneg_reg;
    logic                 wz_reg;
    vtp_pkg::vtp_job_t    job_reg;
    vtp_pkg::vtp_job_t    job_next;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (c % 2 == 1)
                    mc[r][c] = coef[2 * r + c / 2][63:32];
                else
                    mc[r][c] = coef[2 * r + c / 2][31:0];
            end
        end
        xv[0] = in_data.in_x;
        xv[1] = in_data.in_y;
        xv[2] = in_data.in_z;
    end

    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || job_ready;
        for (int i = NST - 2; i >= 0; i--)
            adv[i] = !v_reg[i] || adv[i+1];
    end

    assign in_stall  = !adv[0];
    assign job_valid = v_reg[NST-1];
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Divide setup: overflow test and the first partial remainder.
    always_comb
    begin
        logic [BW-1:0] nsh;
        logic [BW-1:0] dsh;
        logic          bg;
        job_next       = '0;
        job_next.d     = d_reg;
        job_next.w_neg = wneg_reg;
        job_next.wz    = wz_reg;
        dsh = BW'(d_reg) << QW;
        for (int c = 0; c < 3; c++)
        begin
            nsh = BW'(n_reg[c]) << FRAC_BITS;
            bg  = nsh >= dsh;
            job_next.c[c].n   = n_reg[c];
            job_next.c[c].neg = neg_reg[c];
            job_next.c[c].big = bg;
            job_next.c[c].lo  = nsh[QW-1:0];
            job_next.c[c].q   = '0;
            job_next.c[c].rem = bg ? '0 : nsh[BW-1:QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 4; c++)
                    p_reg[r][c] <= xv[r] * mc[r][c];
            end
        end
        if (adv[1])
        begin
            for (int c = 0; c < 4; c++)
                s_reg[c] <= 66'(p_reg[0][c]) + 66'(p_reg[1][c]) + 66'(p_reg[2][c]);
        end
        if (adv[2])
        begin
            for (int c = 0; c < 4; c++)
                col_reg[c] <= CW'(s_reg[c] >>> FRAC_BITS) + CW'(mc[3][c]);
        end
        if (adv[3])
        begin
            for (int c = 0; c < 3; c++)
            begin
                neg_reg[c] <= col_reg[c][CW-1];
                n_reg[c]   <= col_reg[c][CW-1] ? (~col_reg[c] + 1'b1) : col_reg[c];
            end
            wneg_reg <= col_reg[3][CW-1];
            wz_reg   <= col_reg[3] == '0;
            d_reg    <= col_reg[3][CW-1] ? (~col_reg[3] + 1'b1) : col_reg[3];
        end
        if (adv[4])
            job_reg <= job_next;
    end

endmodule
`default_nettype wire

// ----- rtl/vtp_queue.sv -----
// Short item queue between the front and back pipelines.
// Depends on vtp_pkg.
`default_nettype none
module vtp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_valid,
    output logic                    wr_ready,
    input  wire vtp_pkg::vtp_job_t  wr_data,
    output logic                    rd_valid,
    input  wire logic               rd_ready,
    output vtp_pkg::vtp_job_t       rd_data
);

    localparam int DEPTH = vtp_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    vtp_pkg::vtp_job_t mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       cnt_reg;
    logic              push;
    logic              pop;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ----- rtl/vtp_back.sv -----
// Back pipeline: one restoring divide step per stage, then saturation and the output register.
// Depends on vtp_pkg.
`default_nettype none
module vtp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  wire vtp_pkg::vtp_job_t  job,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output vtp_pkg::vtp_out_t       out_data
);

    localparam int CW  = vtp_pkg::CW;
    localparam int QW  = vtp_pkg::QW;
    localparam int NST = QW + 1;
    localparam logic [CW-1:0] POS_MAX = CW'(33'h0_7FFF_FFFF);
    localparam logic [CW-1:0] NEG_MAX = CW'(33'h0_8000_0000);

    logic [NST-1:0]    v_reg;
    logic [NST-1:0]    adv;
    vtp_pkg::vtp_job_t st_reg [QW];
    vtp_pkg::vtp_out_t out_reg;
    vtp_pkg::vtp_out_t out_next;

    function automatic vtp_pkg::vtp_job_t div_step(input vtp_pkg::vtp_job_t j);
        vtp_pkg::vtp_job_t r;
        logic [CW:0]       t;
        logic              qb;
        r = j;
        for (int c = 0; c < 3; c++)
        begin
            t  = {j.c[c].rem, j.c[c].lo[QW-1]};
            qb = t >= {1'b0, j.d};
            r.c[c].rem = qb ? CW'(t - {1'b0, j.d}) : t[CW-1:0];
            r.c[c].q   = {j.c[c].q[QW-2:0], qb};
            r.c[c].lo  = {j.c[c].lo[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int i = NST - 2; i >= 0; i--)
            adv[i] = !v_reg[i] || adv[i+1];
    end

    assign job_ready = adv[0];
    assign out_valid = v_reg[NST-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= job_valid;
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Sign, saturation and the zero-w pass-through.
    always_comb
    begin
        vtp_pkg::vtp_job_t j;
        logic [CW-1:0]     m;
        logic              bg;
        logic              ng;
        logic [31:0]       res [3];
        logic              sat;
        j   = st_reg[QW-1];
        sat = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            if (j.wz)
            begin
                m  = j.c[c].n;
                bg = 1'b0;
                ng = j.c[c].neg;
            end
            else
            begin
                m  = CW'(j.c[c].q);
                bg = j.c[c].big;
                ng = (j.c[c].neg ^ j.w_neg) && (bg || m != '0);
            end
            if (!ng)
            begin
                if (bg || m > POS_MAX)
                begin
                    res[c] = POS_MAX[31:0];
                    sat    = 1'b1;
                end
                else
                    res[c] = m[31:0];
            end
            else
            begin
                if (bg || m > NEG_MAX)
                begin
                    res[c] = NEG_MAX[31:0];
                    sat    = 1'b1;
                end
                else
                    res[c] = ~m[31:0] + 1'b1;
            end
        end
        out_next.out_x      = res[0];
        out_next.out_y      = res[1];
        out_next.out_z      = res[2];
        out_next.w_was_zero = j.wz;
        out_next.saturated  = sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            st_reg[0] <= div_step(job);
        for (int i = 1; i < QW; i++)
        begin
            if (adv[i])
                st_reg[i] <= div_step(st_reg[i-1]);
        end
        if (adv[NST-1])
            out_reg <= out_next;
    end

endmodule
`default_nettype wire

// ----- rtl/vertex_transform_perspective_divide_top.sv -----
// Throughput: one item per cycle while the output is not stalled; every stage, including each
// divide step, is pipelined. The front has 5 stages, the divider 32 steps, and saturation 1;
// the queue registers each item between the front and the divider.
// Reset (rst_n, asynchronous, active low) empties the pipelines and the queue and loads
// the identity matrix into the coefficient registers.
`default_nettype none
module vertex_transform_perspective_divide_top #(
    parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Input items: one point per handshake.
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire vtp_pkg::vtp_in_t           in_data,
    // Result items.
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output vtp_pkg::vtp_out_t               out_data,
    // Coefficient writes.
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [vtp_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]                cfg_data
);

    logic [63:0]       coef_reg [vtp_pkg::NUM_REGS];
    logic              f_valid;
    logic              f_ready;
    vtp_pkg::vtp_job_t f_job;
    logic              q_valid;
    logic              q_ready;
    vtp_pkg::vtp_job_t q_job;

    // The coefficient registers always take a write; an index past the last
    // register is accepted and dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vtp_pkg::NUM_REGS; i++)
                coef_reg[i] <= vtp_pkg::coef_reset(i);
        end
        else if (cfg_valid && cfg_ready
                 && cfg_index < vtp_pkg::IDX_W'(vtp_pkg::NUM_REGS))
        begin
            coef_reg[cfg_index[vtp_pkg::REG_AW-1:0]] <= cfg_data;
        end
    end

    // The front computes the homogeneous point and prepares each divide.
    vtp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .coef      (coef_reg),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    // The queue lets the front keep working while the output side is stalled.
    vtp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_job)
    );

    // The back runs the three divides side by side and saturates the results.
    vtp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ----- rtl/vtp_checker.sv -----
// Port-level checks for the vertex transform top level, bound to it below.
// Depends on vtp_pkg and vertex_transform_perspective_divide_top.
`default_nettype none
module vtp_port_asserts (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire vtp_pkg::vtp_out_t          out_data,
    input wire logic                       cfg_valid,
    input wire logic                       cfg_ready
);

    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

    // A saturated item must show a clipped coordinate.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            out_data.out_x == 32'sh7FFF_FFFF || out_data.out_x == 32'sh8000_0000 ||
            out_data.out_y == 32'sh7FFF_FFFF || out_data.out_y == 32'sh8000_0000 ||
            out_data.out_z == 32'sh7FFF_FFFF || out_data.out_z == 32'sh8000_0000)
    else $error("saturated flag without a clipped coordinate");

    // Coefficient writes are never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("coefficient write held off");

    // An offered input item always sees a defined stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_stall))
    else $error("input stall undefined while an item is offered");

endmodule

bind vertex_transform_perspective_divide_top vtp_port_asserts u_vtp_port_asserts (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
